FILE: design/sak_pkg.sv
// Package for the sequence acknowledgement window.
// Holds field widths, default parameter values and the controller/datapath
// command and status structures. No dependencies.
package sak_pkg;

    // Fixed widths of the stream fields.
    localparam int OP_W       = 1;
    localparam int SLOT_W     = 4;
    localparam int SEQ_IN_W   = 16;
    localparam int LATEST_W   = 16;
    localparam int ACK_W      = 32;

    // Packed stream widths: slave tdata is slot then sequence, padded to 24 bits.
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 48;

    // Default sizes of the per-client table.
    localparam int NUM_CLIENTS_DEF = 16;
    localparam int SEQ_BITS_DEF    = 16;
    localparam int WINDOW_DEF      = 32;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;   // register the incoming transaction
        logic load_out;  // compute, update the table and load the output register
    } sak_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_busy;  // output register holds a result that is not taken this cycle
    } sak_status_t;

endpackage

FILE: design/sak_ctrl.sv
// Controller state machine for the sequence acknowledgement window.
// Sequences capture, table read and update; depends on sak_pkg.
module sak_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  sak_pkg::sak_status_t status,
    output sak_pkg::sak_cmd_t    cmd
);
    import sak_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_CALC = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Next-state logic and commands.
    always_comb begin
        state_next   = state_reg;
        s_tready     = 1'b0;
        cmd.capture  = 1'b0;
        cmd.load_out = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
                if (s_tvalid) begin
                    state_next = S_READ;
                end
            end
            S_READ: begin
                state_next = S_CALC;
            end
            S_CALC: begin
                if (!status.out_busy) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: design/sak_datapath.sv
// Datapath for the sequence acknowledgement window: input register, per-client
// table with valid bits, window update logic and output register. Depends on sak_pkg.
module sak_datapath #(
    parameter int NUM_CLIENTS = sak_pkg::NUM_CLIENTS_DEF,
    parameter int SEQ_BITS    = sak_pkg::SEQ_BITS_DEF,
    parameter int WINDOW      = sak_pkg::WINDOW_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  sak_pkg::sak_cmd_t             cmd,
    output sak_pkg::sak_status_t          status,
    input  logic [sak_pkg::OP_W-1:0]      in_op,
    input  logic [sak_pkg::SLOT_W-1:0]    in_slot,
    input  logic [sak_pkg::SEQ_IN_W-1:0]  in_seq,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          out_discard,
    output logic [sak_pkg::LATEST_W-1:0]  out_latest,
    output logic [sak_pkg::ACK_W-1:0]     out_ack
);
    import sak_pkg::*;

    localparam int IDX_W      = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;
    localparam int SLOT_EXT_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
    localparam int CMP_W      = SLOT_EXT_W + 2;
    localparam int DIST_W     = $clog2(WINDOW + 1);
    localparam int ENTRY_W    = SEQ_BITS + WINDOW;
    localparam logic [SEQ_BITS-1:0] HALF   = {1'b1, {(SEQ_BITS-1){1'b0}}};
    localparam logic [SEQ_BITS-1:0] WIN_SQ = SEQ_BITS'(WINDOW);

    // Captured transaction.
    logic                  op_reg;
    logic [SLOT_W-1:0]     slot_reg;
    logic [SEQ_BITS-1:0]   seq_reg;

    // Table, valid bits and registered read port.
    logic [ENTRY_W-1:0]    mem [NUM_CLIENTS];
    logic [NUM_CLIENTS-1:0] valid_reg;
    logic [ENTRY_W-1:0]    rd_data_reg;
    logic                  rd_valid_reg;

    // Output register.
    logic                  out_valid_reg;
    logic                  discard_reg;
    logic [LATEST_W-1:0]   latest_reg;
    logic [ACK_W-1:0]      ack_reg;

    logic [SEQ_BITS+SEQ_IN_W-1:0] seq_wide;
    logic [SLOT_EXT_W-1:0] slot_ext;
    logic [IDX_W-1:0]      idx;
    logic                  in_range;
    logic [SEQ_BITS-1:0]   cur_latest;
    logic [WINDOW-1:0]     cur_bits;
    logic [SEQ_BITS-1:0]   fwd_dist;
    logic [SEQ_BITS-1:0]   age;
    logic [DIST_W-1:0]     fwd_dist_s;
    logic [DIST_W-1:0]     age_s;
    logic                  newer;
    logic [WINDOW-1:0]     age_bit;
    logic [SEQ_BITS-1:0]   new_latest;
    logic [WINDOW-1:0]     new_bits;
    logic                  new_discard;
    logic [SEQ_BITS+LATEST_W-1:0] latest_wide;
    logic [WINDOW+ACK_W-1:0]      bits_wide;

    // Reduce the incoming sequence to SEQ_BITS.
    assign seq_wide = {{SEQ_BITS{1'b0}}, in_seq};

    // Capture the accepted transaction.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg   <= in_op[0];
            slot_reg <= in_slot;
            seq_reg  <= seq_wide[SEQ_BITS-1:0];
        end
    end

    // Slot decoding and range check.
    assign slot_ext = SLOT_EXT_W'(slot_reg);
    assign idx      = slot_ext[IDX_W-1:0];
    assign in_range = (CMP_W'(slot_reg) < CMP_W'(NUM_CLIENTS));

    // Table read, registered.
    always_ff @(posedge aclk) begin
        rd_data_reg  <= mem[idx];
        rd_valid_reg <= valid_reg[idx];
    end

    // Current slot state; a first-contact transaction or an unwritten entry reads as zero.
    always_comb begin
        if (op_reg || !rd_valid_reg) begin
            cur_latest = '0;
            cur_bits   = '0;
        end else begin
            cur_latest = rd_data_reg[ENTRY_W-1:WINDOW];
            cur_bits   = rd_data_reg[WINDOW-1:0];
        end
    end

    // Serial comparison against the latest sequence.
    assign fwd_dist   = seq_reg - cur_latest;
    assign age        = cur_latest - seq_reg;
    assign fwd_dist_s = fwd_dist[DIST_W-1:0];
    assign age_s      = age[DIST_W-1:0];
    assign newer      = (fwd_dist != '0) && (!fwd_dist[SEQ_BITS-1] || (fwd_dist == HALF));
    assign age_bit    = WINDOW'(1) << (age_s - DIST_W'(1));

    // Window update.
    always_comb begin
        new_latest  = cur_latest;
        new_bits    = cur_bits;
        new_discard = 1'b1;
        if (newer) begin
            new_latest  = seq_reg;
            new_discard = 1'b0;
            if (fwd_dist > WIN_SQ) begin
                new_bits = '0;
            end else begin
                new_bits = (cur_bits << fwd_dist_s) |
                           (WINDOW'(1) << (fwd_dist_s - DIST_W'(1)));
            end
        end else if (fwd_dist != '0) begin
            // Older: accepted once when inside the window.
            if ((age <= WIN_SQ) && ((cur_bits & age_bit) == '0)) begin
                new_bits    = cur_bits | age_bit;
                new_discard = 1'b0;
            end
        end
    end

    // Table write and valid bits.
    always_ff @(posedge aclk) begin
        if (cmd.load_out && in_range) begin
            mem[idx] <= {new_latest, new_bits};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (cmd.load_out && in_range) begin
            valid_reg[idx] <= 1'b1;
        end
    end

    // Fit the results to the output field widths.
    assign latest_wide = {{LATEST_W{1'b0}}, new_latest};
    assign bits_wide   = {{ACK_W{1'b0}}, new_bits};

    // Output register; an out-of-range slot reports discard with zero fields.
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            discard_reg <= in_range ? new_discard : 1'b1;
            latest_reg  <= in_range ? latest_wide[LATEST_W-1:0] : '0;
            ack_reg     <= in_range ? bits_wide[ACK_W-1:0] : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.out_busy = out_valid_reg && !out_ready;
    assign out_valid   = out_valid_reg;
    assign out_discard = discard_reg;
    assign out_latest  = latest_reg;
    assign out_ack     = ack_reg;

endmodule

FILE: design/sequence_ack_window.sv
// Sequence acknowledgement window: per-client 32-bit anti-replay window.
// Path: input register, table read register, then the m_ output register.
// One transaction is handled at a time, in the capture, table read and update steps
// of the controller; a waiting result stalls only the update step.
// Reset (aresetn low, synchronous) empties the output register and clears the
// table's valid bits, so every slot reads as sequence 0 with an empty bitmap.
module sequence_ack_window #(
    parameter int NUM_CLIENTS = sak_pkg::NUM_CLIENTS_DEF,
    parameter int SEQ_BITS    = sak_pkg::SEQ_BITS_DEF,
    parameter int WINDOW      = sak_pkg::WINDOW_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [sak_pkg::S_TDATA_W-1:0]  s_tdata,  // client_slot[3:0], seq_in[19:4], zero pad
    input  logic                           s_tuser,  // op
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [sak_pkg::M_TDATA_W-1:0]  m_tdata,  // latest_seq[15:0], ack_bits[47:16]
    output logic                           m_tuser   // discard
);
    import sak_pkg::*;

    sak_cmd_t    cmd;
    sak_status_t status;

    // Controller.
    sak_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath.
    sak_datapath #(
        .NUM_CLIENTS (NUM_CLIENTS),
        .SEQ_BITS    (SEQ_BITS),
        .WINDOW      (WINDOW)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .in_op       (s_tuser),
        .in_slot     (s_tdata[SLOT_W-1:0]),
        .in_seq      (s_tdata[SLOT_W+SEQ_IN_W-1:SLOT_W]),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_discard (m_tuser),
        .out_latest  (m_tdata[LATEST_W-1:0]),
        .out_ack     (m_tdata[LATEST_W+ACK_W-1:LATEST_W])
    );

endmodule
